FILE: rtl/core/mts_pkg.sv
package mts_pkg;

    // Default sizes of the texel store and the mip pyramid.
    localparam int TEXEL_DEPTH_DEF = 131072;
    localparam int MAX_LEVELS_DEF  = 14;

    // Field and datapath widths.
    localparam int SIZE_W      = 13;
    localparam int LVL_W       = 4;
    localparam int ADDR_W      = 22;
    localparam int LIN_W       = 25;
    localparam int MAX_SIZE    = 4096;
    localparam int QUEUE_DEPTH = 16;
    localparam int OUT_DEPTH   = 4;
    localparam int CFG_IDX_W   = 1;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT = 1'b1;

    // Item functions.
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef struct packed {
        logic        func;
        logic [16:0] texel_addr;
        logic [31:0] texel_data;
        logic [15:0] u;
        logic [15:0] v;
        logic [15:0] dx_u;
        logic [15:0] dx_v;
        logic [15:0] dy_u;
        logic [15:0] dy_v;
        logic        pixel_mode;
        logic        level_mode;
    } t_in_word;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [3:0] level_used;
    } t_out_word;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] idx;
        logic [SIZE_W-1:0]    data;
    } t_cfg_wr;

    // One memory job: a texel write, or one or four texel reads and a blend.
    typedef struct packed {
        logic                   is_load;
        logic                   bilinear;
        logic [LVL_W-1:0]       level;
        logic [7:0]             wu;
        logic [7:0]             wv;
        logic [3:0][ADDR_W-1:0] addr;
        logic [31:0]            data;
    } t_job;

endpackage

FILE: rtl/core/mts_ram.sv
module mts_ram
    import mts_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = TEXEL_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port with a registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/mts_queue.sv
module mts_queue
    import mts_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_job          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;

    // Entry storage; the front guarantees room by its credit count.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == (PW+1)'(QUEUE_DEPTH)) |-> (!i_push || i_pop))
        else $error("job queue pushed while full");
`endif

endmodule

FILE: rtl/core/mts_front.sv
module mts_front
    import mts_pkg::*;
#(
    parameter int TEXEL_DEPTH = TEXEL_DEPTH_DEF,
    parameter int MAX_LEVELS  = MAX_LEVELS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg_wr  i_cfg,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_word i_in_word,
    input  logic     i_pop,
    output logic     o_push,
    output t_job     o_job
);

    localparam int     MAW   = $clog2(TEXEL_DEPTH);
    localparam longint RECIP = (64'd1 << LIN_W) / TEXEL_DEPTH;
    localparam int     RW    = $clog2(RECIP + 1);
    localparam int     NG    = (MAX_LEVELS + 3) / 4;
    localparam int     CW    = $clog2(QUEUE_DEPTH + 1);

    function automatic logic [SIZE_W-1:0] lvl_dim(logic [SIZE_W-1:0] s, logic [LVL_W-1:0] k);
        logic [SIZE_W-1:0] t;
        t = s >> k;
        return (t == '0) ? SIZE_W'(1) : t;
    endfunction

    function automatic logic [5:0] msb59(logic [58:0] x);
        logic [5:0] m;
        m = '0;
        for (int i = 0; i < 59; i++) begin
            if (x[i]) m = 6'(i);
        end
        return m;
    endfunction

    function automatic logic [15:0] absdiff(logic [15:0] a, logic [15:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // Configuration: clamped level-0 size, per-level sizes and last level.
    logic [SIZE_W-1:0] r_w, r_h, n_sz;
    logic [LIN_W-1:0]  r_size [MAX_LEVELS];
    logic [LVL_W-1:0]  r_last;
    logic [SIZE_W-1:0] big;
    logic [3:0]        big_msb;

    always_comb begin
        if (i_cfg.data == '0)                       n_sz = SIZE_W'(1);
        else if (i_cfg.data > SIZE_W'(MAX_SIZE))    n_sz = SIZE_W'(MAX_SIZE);
        else                                        n_sz = i_cfg.data;
        big     = (r_w > r_h) ? r_w : r_h;
        big_msb = '0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (big[i]) big_msb = 4'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= SIZE_W'(256);
            r_h <= SIZE_W'(256);
        end else if (i_cfg.we) begin
            unique case (i_cfg.idx)
                CFG_TEX_WIDTH:  r_w <= n_sz;
                CFG_TEX_HEIGHT: r_h <= n_sz;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_LEVELS; k++) begin
            r_size[k] <= LIN_W'(26'(lvl_dim(r_w, LVL_W'(k))) * 26'(lvl_dim(r_h, LVL_W'(k))));
        end
        r_last <= (LVL_W'(big_msb) > LVL_W'(MAX_LEVELS - 1)) ?
                  LVL_W'(MAX_LEVELS - 1) : LVL_W'(big_msb);
    end

    // Credit for queue entries: words in the pipeline plus words queued.
    logic [CW-1:0] r_used;
    logic          accept;

    assign o_in_stall = (r_used >= CW'(QUEUE_DEPTH));
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_used <= '0;
        else          r_used <= r_used + CW'(accept) - CW'(i_pop);
    end

    // Pipeline valid bits, one per stage.
    logic [13:1] r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else          r_v <= {r_v[12:1], accept};
    end

    // Stage 1: capture the word.
    t_in_word r1_word;
    always_ff @(posedge i_clk) r1_word <= i_in_word;

    // Stage 2: neighbour offsets scaled to texels.
    t_in_word          r2_word;
    logic [28:0]       r2_d [4];
    always_ff @(posedge i_clk) begin
        r2_word <= r1_word;
        r2_d[0] <= 29'(absdiff(r1_word.dx_u, r1_word.u)) * 29'(r_w);
        r2_d[1] <= 29'(absdiff(r1_word.dx_v, r1_word.v)) * 29'(r_h);
        r2_d[2] <= 29'(absdiff(r1_word.dy_u, r1_word.u)) * 29'(r_w);
        r2_d[3] <= 29'(absdiff(r1_word.dy_v, r1_word.v)) * 29'(r_h);
    end

    // Stage 3: squares.
    t_in_word    r3_word;
    logic [57:0] r3_sq [4];
    always_ff @(posedge i_clk) begin
        r3_word <= r2_word;
        for (int i = 0; i < 4; i++) begin
            r3_sq[i] <= 58'(r2_d[i]) * 58'(r2_d[i]);
        end
    end

    // Stage 4: larger squared distance of the two neighbours.
    t_in_word    r4_word;
    logic [58:0] r4_s;
    logic [58:0] s_x, s_y;
    always_comb begin
        s_x = 59'(r3_sq[0]) + 59'(r3_sq[1]);
        s_y = 59'(r3_sq[2]) + 59'(r3_sq[3]);
    end
    always_ff @(posedge i_clk) begin
        r4_word <= r3_word;
        r4_s    <= (s_x > s_y) ? s_x : s_y;
    end

    // Stage 5: level from the leading one, clamped to the last level; level 0 when level_mode is clear.
    t_in_word         r5_word;
    logic [LVL_W-1:0] r5_lvl;
    logic [4:0]       half;
    logic [LVL_W-1:0] lvl;
    always_comb begin
        half = 5'(msb59(r4_s) >> 1);
        if (!r4_word.level_mode || r4_s == '0 || half < 5'd16) lvl = '0;
        else                                                  lvl = LVL_W'(half - 5'd16);
        if (lvl > r_last) lvl = r_last;
    end
    always_ff @(posedge i_clk) begin
        r5_word <= r4_word;
        r5_lvl  <= lvl;
    end

    // Stage 6: partial sums of the lower level sizes, level dimensions.
    t_in_word          r6_word;
    logic [LVL_W-1:0]  r6_lvl;
    logic [LIN_W-1:0]  r6_part [NG];
    logic [SIZE_W-1:0] r6_wk, r6_hk;
    always_ff @(posedge i_clk) begin
        r6_word <= r5_word;
        r6_lvl  <= r5_lvl;
        r6_wk   <= lvl_dim(r_w, r5_lvl);
        r6_hk   <= lvl_dim(r_h, r5_lvl);
        for (int g = 0; g < NG; g++) begin
            logic [LIN_W-1:0] acc;
            acc = '0;
            for (int j = 0; j < 4; j++) begin
                if (g * 4 + j < MAX_LEVELS && LVL_W'(g * 4 + j) < r5_lvl) begin
                    acc = acc + r_size[g * 4 + j];
                end
            end
            r6_part[g] <= acc;
        end
    end

    // Stage 7: level base address and scaled coordinates.
    t_in_word          r7_word;
    logic [LVL_W-1:0]  r7_lvl;
    logic [LIN_W-1:0]  r7_base;
    logic [SIZE_W-1:0] r7_wk, r7_hk;
    logic [28:0]       r7_fu, r7_fv;
    logic [LIN_W-1:0]  base_sum;
    always_comb begin
        base_sum = '0;
        for (int g = 0; g < NG; g++) base_sum = base_sum + r6_part[g];
    end
    always_ff @(posedge i_clk) begin
        r7_word <= r6_word;
        r7_lvl  <= r6_lvl;
        r7_base <= base_sum;
        r7_wk   <= r6_wk;
        r7_hk   <= r6_hk;
        r7_fu   <= 29'(r6_word.u) * 29'(r6_wk);
        r7_fv   <= 29'(r6_word.v) * 29'(r6_hk);
    end

    // Job fields carried from stage 8 on.
    typedef struct packed {
        logic             is_load;
        logic             bilinear;
        logic [LVL_W-1:0] level;
        logic [7:0]       wu;
        logic [7:0]       wv;
        logic [16:0]      taddr;
        logic [31:0]      data;
    } t_meta;

    // Stage 8: clamped texel columns and rows, blend weights.
    t_meta             r8_meta;
    logic [LIN_W-1:0]  r8_base;
    logic [SIZE_W-1:0] r8_wk;
    logic [SIZE_W-1:0] r8_x0, r8_x1, r8_y0, r8_y1;
    logic [SIZE_W-1:0] x0, y0;
    always_comb begin
        x0 = (r7_fu[28:16] > r7_wk - 1'b1) ? r7_wk - 1'b1 : r7_fu[28:16];
        y0 = (r7_fv[28:16] > r7_hk - 1'b1) ? r7_hk - 1'b1 : r7_fv[28:16];
    end
    always_ff @(posedge i_clk) begin
        r8_meta.is_load  <= (r7_word.func == FUNC_LOAD);
        r8_meta.bilinear <= r7_word.pixel_mode;
        r8_meta.level    <= r7_lvl;
        r8_meta.wu       <= r7_word.pixel_mode ? r7_fu[15:8] : 8'd0;
        r8_meta.wv       <= r7_word.pixel_mode ? r7_fv[15:8] : 8'd0;
        r8_meta.taddr    <= r7_word.texel_addr;
        r8_meta.data     <= r7_word.texel_data;
        r8_base <= r7_base;
        r8_wk   <= r7_wk;
        r8_x0   <= x0;
        r8_y0   <= y0;
        r8_x1   <= (x0 + 1'b1 < r7_wk) ? x0 + 1'b1 : r7_wk - 1'b1;
        r8_y1   <= (y0 + 1'b1 < r7_hk) ? y0 + 1'b1 : r7_hk - 1'b1;
    end

    // Stage 9: row offsets.
    t_meta             r9_meta;
    logic [LIN_W-1:0]  r9_base, r9_yw0, r9_yw1;
    logic [SIZE_W-1:0] r9_x0, r9_x1;
    always_ff @(posedge i_clk) begin
        r9_meta <= r8_meta;
        r9_base <= r8_base;
        r9_x0   <= r8_x0;
        r9_x1   <= r8_x1;
        r9_yw0  <= LIN_W'(26'(r8_y0) * 26'(r8_wk));
        r9_yw1  <= LIN_W'(26'(r8_y1) * 26'(r8_wk));
    end

    // Stage 10: linear addresses of the four corners, or the load address.
    t_meta            r10_meta;
    logic [LIN_W-1:0] r10_lin [4];
    always_ff @(posedge i_clk) begin
        r10_meta <= r9_meta;
        if (r9_meta.is_load) begin
            r10_lin[0] <= LIN_W'(r9_meta.taddr);
        end else begin
            r10_lin[0] <= r9_base + r9_yw0 + LIN_W'(r9_x0);
        end
        r10_lin[1] <= r9_base + r9_yw0 + LIN_W'(r9_x1);
        r10_lin[2] <= r9_base + r9_yw1 + LIN_W'(r9_x0);
        r10_lin[3] <= r9_base + r9_yw1 + LIN_W'(r9_x1);
    end

    // Stage 11: quotient estimate by the reciprocal of the depth.
    t_meta            r11_meta;
    logic [LIN_W-1:0] r11_lin [4];
    logic [RW-1:0]    r11_q   [4];
    always_ff @(posedge i_clk) begin
        r11_meta <= r10_meta;
        for (int i = 0; i < 4; i++) begin
            logic [LIN_W+RW-1:0] p;
            p = (LIN_W+RW)'(r10_lin[i]) * (LIN_W+RW)'(RECIP);
            r11_lin[i] <= r10_lin[i];
            r11_q[i]   <= p[LIN_W+RW-1:LIN_W];
        end
    end

    // Stage 12: remainder, below twice the depth.
    t_meta          r12_meta;
    logic [MAW:0]   r12_rem [4];
    always_ff @(posedge i_clk) begin
        r12_meta <= r11_meta;
        for (int i = 0; i < 4; i++) begin
            logic [LIN_W-1:0] qd;
            qd = LIN_W'((LIN_W+RW)'(r11_q[i]) * (LIN_W+RW)'(TEXEL_DEPTH));
            r12_rem[i] <= (MAW+1)'(r11_lin[i] - qd);
        end
    end

    // Stage 13: final correction and the job word.
    t_job r13_job;
    always_ff @(posedge i_clk) begin
        r13_job.is_load  <= r12_meta.is_load;
        r13_job.bilinear <= r12_meta.bilinear;
        r13_job.level    <= r12_meta.level;
        r13_job.wu       <= r12_meta.wu;
        r13_job.wv       <= r12_meta.wv;
        r13_job.data     <= r12_meta.data;
        for (int i = 0; i < 4; i++) begin
            if (r12_rem[i] >= (MAW+1)'(TEXEL_DEPTH)) begin
                r13_job.addr[i] <= ADDR_W'(r12_rem[i] - (MAW+1)'(TEXEL_DEPTH));
            end else begin
                r13_job.addr[i] <= ADDR_W'(r12_rem[i]);
            end
        end
    end

    assign o_push = r_v[13];
    assign o_job  = r13_job;

`ifndef NO_ASSERTIONS
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(QUEUE_DEPTH))
        else $error("front credit count beyond queue depth");
`endif

endmodule

FILE: rtl/core/mts_back.sv
module mts_back
    import mts_pkg::*;
#(
    parameter int TEXEL_DEPTH = TEXEL_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    input  t_job      i_job,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    localparam int MAW = $clog2(TEXEL_DEPTH);
    localparam int OPW = $clog2(OUT_DEPTH);

    // Issue sequencer: one memory access per cycle while a job is in hand.
    t_job       r_job;
    logic       r_busy;
    logic [1:0] r_idx;
    logic [2:0] r_pend;
    logic       last_issue, can_take, out_acc;

    assign last_issue = r_busy && (r_job.is_load || !r_job.bilinear || r_idx == 2'd3);
    assign can_take   = !r_busy || last_issue;
    assign o_pop      = i_job_valid && can_take &&
                        (i_job.is_load || r_pend < 3'(OUT_DEPTH));
    assign out_acc    = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_pend <= '0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (last_issue) begin
                r_busy <= 1'b0;
            end else if (r_busy) begin
                r_idx <= r_idx + 1'b1;
            end
            r_pend <= r_pend + 3'(o_pop && !i_job.is_load) - 3'(out_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_job <= i_job;
    end

    // Texel memory.
    logic        ram_we;
    logic [31:0] ram_rdata;

    assign ram_we = r_busy && r_job.is_load;

    mts_ram #(
        .WIDTH(32),
        .DEPTH(TEXEL_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (r_job.addr[r_idx][MAW-1:0]),
        .i_wdata (r_job.data),
        .o_rdata (ram_rdata)
    );

    // Read tags, registered to line up with the memory read data.
    logic             r_rd_v, r_rd_last, r_rd_bil;
    logic [1:0]       r_rd_idx;
    logic [7:0]       r_rd_wu, r_rd_wv;
    logic [LVL_W-1:0] r_rd_lvl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v    <= 1'b0;
            r_rd_last <= 1'b0;
        end else begin
            r_rd_v    <= r_busy && !r_job.is_load;
            r_rd_last <= last_issue && !r_job.is_load;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx;
        r_rd_bil <= r_job.bilinear;
        r_rd_wu  <= r_job.wu;
        r_rd_wv  <= r_job.wv;
        r_rd_lvl <= r_job.level;
    end

    // Corner texels: the word arriving now overrides the stored one; a nearest sample uses corner 0 for all four.
    logic [31:0] r_tex [4];
    logic [31:0] tex   [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            tex[i] = (r_rd_idx == 2'(i)) ? ram_rdata : r_tex[i];
        end
        if (!r_rd_bil) begin
            for (int i = 1; i < 4; i++) tex[i] = tex[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_v) r_tex[r_rd_idx] <= ram_rdata;
    end

    // Blend stage 1: horizontal blend of both rows.
    logic             r_b1_v;
    logic [15:0]      r_top [4];
    logic [15:0]      r_bot [4];
    logic [7:0]       r_b1_wv;
    logic [LVL_W-1:0] r_b1_lvl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b1_v <= 1'b0;
        else          r_b1_v <= r_rd_last;
    end

    always_ff @(posedge i_clk) begin
        r_b1_wv  <= r_rd_wv;
        r_b1_lvl <= r_rd_lvl;
        for (int ch = 0; ch < 4; ch++) begin
            r_top[ch] <= 16'(17'(tex[0][8*ch +: 8]) * 17'(9'd256 - 9'(r_rd_wu)) +
                             17'(tex[1][8*ch +: 8]) * 17'(r_rd_wu));
            r_bot[ch] <= 16'(17'(tex[2][8*ch +: 8]) * 17'(9'd256 - 9'(r_rd_wu)) +
                             17'(tex[3][8*ch +: 8]) * 17'(r_rd_wu));
        end
    end

    // Blend stage 2: vertical blend with rounding.
    t_out_word   res;
    logic [24:0] mix [4];

    always_comb begin
        for (int ch = 0; ch < 4; ch++) begin
            mix[ch] = 25'(r_top[ch]) * 25'(9'd256 - 9'(r_b1_wv)) +
                      25'(r_bot[ch]) * 25'(r_b1_wv) + 25'd32768;
        end
        res.red        = mix[0][23:16];
        res.green      = mix[1][23:16];
        res.blue       = mix[2][23:16];
        res.alpha      = mix[3][23:16];
        res.level_used = r_b1_lvl;
    end

    // Output buffer; the pending count keeps it from overflowing.
    t_out_word      r_of [OUT_DEPTH];
    logic [OPW-1:0] r_owp, r_orp;
    logic [OPW:0]   r_ocnt;

    always_ff @(posedge i_clk) begin
        if (r_b1_v) r_of[r_owp] <= res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            if (r_b1_v)  r_owp <= r_owp + 1'b1;
            if (out_acc) r_orp <= r_orp + 1'b1;
            r_ocnt <= r_ocnt + (OPW+1)'(r_b1_v) - (OPW+1)'(out_acc);
        end
    end

    assign o_out_valid = (r_ocnt != '0);
    assign o_out_word  = r_of[r_orp];

`ifndef NO_ASSERTIONS
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 3'(OUT_DEPTH))
        else $error("more samples pending than output buffer entries");
    a_buf_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b1_v |-> (r_ocnt < (OPW+1)'(OUT_DEPTH)) || out_acc)
        else $error("output buffer written while full");
    a_valid_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_pend != '0) && (3'(r_ocnt) <= r_pend))
        else $error("buffered results exceed pending samples");
`endif

endmodule

FILE: rtl/core/mip_texture_sampler.sv
// Channel   Direction  Handshake                 Word
// input     in         i_in_valid / o_in_stall   i_in_word  (t_in_word)
// output    out        o_out_valid / i_out_stall o_out_word (t_out_word)
// config    in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// A bilinear sample reads four texels through the single texel memory
// port; a nearest sample reads one and a load writes one. Reset clears
// control state only; texel memory holds nothing until loaded. Input
// stalls once 16 words sit in the front and the job queue; a sample
// waits in the queue while four issued samples have not yet left the block.
module mip_texture_sampler
    import mts_pkg::*;
#(
    parameter int TEXEL_DEPTH = TEXEL_DEPTH_DEF,
    parameter int MAX_LEVELS  = MAX_LEVELS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_word             i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_word            o_out_word,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SIZE_W-1:0]    i_cfg_data
);

    t_cfg_wr cfg;
    t_job    push_job, head_job;
    logic    push, pop, head_valid;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    // Front: level choice and texel addresses.
    mts_front #(
        .TEXEL_DEPTH(TEXEL_DEPTH),
        .MAX_LEVELS (MAX_LEVELS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .i_pop      (pop),
        .o_push     (push),
        .o_job      (push_job)
    );

    // Queue between address generation and memory access.
    mts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_job   (head_job)
    );

    // Back: texel memory, reads and blending.
    mts_back #(
        .TEXEL_DEPTH(TEXEL_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (head_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule
